// ----- rtl/core/smmd_pkg.sv -----
// Shared constants, register codes and types of the min/max scope decimator.
package smmd_pkg;

	localparam int RING_DEPTH  = 32768;
	localparam int SAMPLE_BITS = 16;
	localparam int RING_AW     = $clog2(RING_DEPTH);

	localparam int WS_W    = 15;
	localparam int SPP_W   = 19;
	localparam int SPP_FRAC = 8;
	localparam int YOFF_W  = 12;
	localparam int YGAIN_W = 11;
	localparam int COL_W   = 12;
	localparam int Y_W     = 14;
	localparam int CNT_W   = SPP_W + 1 - SPP_FRAC;
	localparam int BASE_W  = COL_W + SPP_W - SPP_FRAC;
	localparam int SUM_W   = BASE_W + 2;
	localparam int MUL_W   = 20;
	localparam int PROD_W  = 2 * MUL_W;

	localparam int IN_W    = 32;
	localparam int OUT_W   = COL_W + 2 * Y_W;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic REQ_PUSH   = 1'b0;
	localparam logic REQ_COLUMN = 1'b1;

	localparam logic [1:0] REG_WINDOW_START = 2'd0;
	localparam logic [1:0] REG_SPP_Q8       = 2'd1;
	localparam logic [1:0] REG_Y_OFFSET     = 2'd2;
	localparam logic [1:0] REG_Y_GAIN       = 2'd3;

	localparam logic [WS_W-1:0]    WINDOW_START_RST = WS_W'(30720);
	localparam logic [SPP_W-1:0]   SPP_Q8_RST       = SPP_W'(1024);
	localparam logic [YOFF_W-1:0]  Y_OFFSET_RST     = YOFF_W'(240);
	localparam logic [YGAIN_W-1:0] Y_GAIN_RST       = YGAIN_W'(239);

	typedef struct packed {
		logic [WS_W-1:0]    window_start;
		logic [SPP_W-1:0]   spp_q8;
		logic [YOFF_W-1:0]  y_offset;
		logic [YGAIN_W-1:0] y_gain;
	} cfg_t;

	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
	} rd_req_t;

	// Packed so that column sits in the lowest bits.
	typedef struct packed {
		logic [Y_W-1:0]   second_y;
		logic [Y_W-1:0]   first_y;
		logic [COL_W-1:0] column;
	} res_t;

endpackage

// ----- rtl/core/smmd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module smmd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/smmd_core.sv -----
// Column sequencer: ring scan, min/max tracking and the shared multiplier.
module smmd_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [smmd_pkg::COL_W-1:0]    pixel_index,
	input  smmd_pkg::cfg_t                cfg,
	input  logic [smmd_pkg::RING_AW-1:0]  write_pointer,
	output smmd_pkg::rd_req_t             rd_req,
	input  logic [smmd_pkg::SAMPLE_BITS-1:0] rd_data,
	output logic                          idle,
	output logic                          res_valid,
	input  logic                          res_ready,
	output smmd_pkg::res_t                res
);
	import smmd_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_MUL     = 3'd1;
	localparam logic [2:0] ST_ADDR    = 3'd2;
	localparam logic [2:0] ST_SCAN    = 3'd3;
	localparam logic [2:0] ST_DRAIN   = 3'd4;
	localparam logic [2:0] ST_SCALE_A = 3'd5;
	localparam logic [2:0] ST_SCALE_B = 3'd6;
	localparam logic [2:0] ST_DONE    = 3'd7;

	logic [2:0]                    state_q;
	logic [COL_W-1:0]              col_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic [RING_AW-1:0]            addr_q;
	logic [CNT_W-1:0]              left_q;
	logic                          vld_q;
	logic                          first_q;
	logic                          min_later_q;
	logic signed [SAMPLE_BITS-1:0] mn_q;
	logic signed [SAMPLE_BITS-1:0] mx_q;
	logic [Y_W-1:0]                y_first_q;

	logic signed [MUL_W-1:0]       mul_a;
	logic signed [MUL_W-1:0]       mul_b;
	logic signed [PROD_W-1:0]      prod;
	logic signed [SAMPLE_BITS-1:0] cur;
	logic [SPP_W:0]                spp_up;
	logic [CNT_W-1:0]              n_raw;
	logic [SUM_W-1:0]              base_sum;

	// Screen y is the zero level minus the product floored by the Q1.15 scale.
	function automatic logic [Y_W-1:0] to_screen(input logic signed [PROD_W-1:0] p,
			input logic [YOFF_W-1:0] off);
		logic [Y_W-1:0] q;
		q = p[SAMPLE_BITS-1 +: Y_W];
		return Y_W'(off) - q;
	endfunction

	assign cur      = signed'(rd_data);
	assign spp_up   = (SPP_W + 1)'(cfg.spp_q8) + (SPP_W + 1)'(255);
	assign n_raw    = spp_up[SPP_W -: CNT_W];
	assign base_sum = SUM_W'(write_pointer) + SUM_W'(cfg.window_start)
		+ SUM_W'(prod_q[SPP_FRAC +: BASE_W]);

	always_comb begin
		mul_a = '0;
		mul_b = MUL_W'(cfg.y_gain);
		unique case (state_q)
			ST_MUL: begin
				mul_a = MUL_W'(col_q);
				mul_b = MUL_W'(cfg.spp_q8);
			end
			ST_SCALE_A: mul_a = MUL_W'(min_later_q ? mx_q : mn_q);
			ST_SCALE_B: mul_a = MUL_W'(min_later_q ? mn_q : mx_q);
			default: mul_a = '0;
		endcase
	end

	assign prod = mul_a * mul_b;

	assign rd_req.en   = (state_q == ST_SCAN);
	assign rd_req.addr = addr_q;
	assign idle        = (state_q == ST_IDLE);
	assign res_valid   = (state_q == ST_DONE);
	assign res.column   = col_q;
	assign res.first_y  = y_first_q;
	assign res.second_y = to_screen(prod_q, cfg.y_offset);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_q   <= 1'b0;
			first_q <= 1'b0;
		end else begin
			vld_q <= rd_req.en;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:   state_q <= ST_ADDR;
				ST_ADDR: begin
					first_q <= 1'b1;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (left_q <= CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN:   state_q <= ST_SCALE_A;
				ST_SCALE_A: state_q <= ST_SCALE_B;
				ST_SCALE_B: state_q <= ST_DONE;
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (vld_q) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			col_q <= pixel_index;
		end
		if (state_q == ST_MUL || state_q == ST_SCALE_A || state_q == ST_SCALE_B) begin
			prod_q <= prod;
		end
		if (state_q == ST_SCALE_B) begin
			y_first_q <= to_screen(prod_q, cfg.y_offset);
		end
		if (state_q == ST_ADDR) begin
			addr_q <= base_sum[RING_AW-1:0];
			left_q <= (n_raw == '0) ? CNT_W'(1) : n_raw;
		end else if (state_q == ST_SCAN) begin
			addr_q <= addr_q + RING_AW'(1);
			left_q <= left_q - CNT_W'(1);
		end
		// Read data arrives in the cycle after the read request.
		if (vld_q) begin
			if (first_q) begin
				mn_q        <= cur;
				mx_q        <= cur;
				min_later_q <= 1'b0;
			end else if (cur > mx_q) begin
				mx_q        <= cur;
				min_later_q <= 1'b0;
			end else if (cur < mn_q) begin
				mn_q        <= cur;
				min_later_q <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/scope_minmax_decimator.sv -----
// Peak-detect scope decimator: a push request (tuser 0) stores one Q1.15 sample into a
// 32768-entry ring and is taken whenever the block is idle. A column request (tuser 1)
// scans ceil(samples_per_pixel) samples, at least one, starting at window_start +
// floor(pixel_index * samples_per_pixel) past the oldest sample, and returns the minimum
// and maximum mapped to screen y, the later extremum second. A column request keeps
// s_tready low until its result has passed to the output register: the ring has one read
// port giving one sample per cycle, and a single multiplier forms the start offset and
// both screen values one after another. The result waits in an output register, so the
// next request is taken while it is still held. Ring contents are undefined until written;
// no clearing pass runs after reset. Registers may only be written while idle.
module scope_minmax_decimator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [smmd_pkg::IN_W-1:0]      s_tdata,  // sample[15:0], pixel_index[27:16], zero[31:28]
	input  logic [0:0]                     s_tuser,  // req_type[0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [smmd_pkg::OUT_W-1:0]     m_tdata,  // column[11:0], first_y[25:12], second_y[39:26]
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [smmd_pkg::PADDR_W-1:0]   paddr,
	input  logic [smmd_pkg::PDATA_W-1:0]   pwdata,
	output logic [smmd_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import smmd_pkg::*;

	cfg_t                   cfg_q;
	logic [RING_AW-1:0]     wp_q;
	logic                   out_vld_q;
	res_t                   out_q;

	logic                   accept;
	logic                   push;
	logic                   start;
	logic                   core_idle;
	logic                   res_valid;
	logic                   res_ready;
	res_t                   res;
	rd_req_t                rd_req;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic [1:0]             reg_idx;

	assign accept   = s_tvalid && s_tready;
	assign push     = accept && (s_tuser[0] == REQ_PUSH);
	assign start    = accept && (s_tuser[0] == REQ_COLUMN);
	assign s_tready = core_idle;
	assign pready   = 1'b1;
	assign reg_idx  = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_start <= WINDOW_START_RST;
			cfg_q.spp_q8       <= SPP_Q8_RST;
			cfg_q.y_offset     <= Y_OFFSET_RST;
			cfg_q.y_gain       <= Y_GAIN_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_WINDOW_START: cfg_q.window_start <= pwdata[WS_W-1:0];
				REG_SPP_Q8:       cfg_q.spp_q8       <= pwdata[SPP_W-1:0];
				REG_Y_OFFSET:     cfg_q.y_offset     <= pwdata[YOFF_W-1:0];
				REG_Y_GAIN:       cfg_q.y_gain       <= pwdata[YGAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_START: prdata = PDATA_W'(cfg_q.window_start);
			REG_SPP_Q8:       prdata = PDATA_W'(cfg_q.spp_q8);
			REG_Y_OFFSET:     prdata = PDATA_W'(cfg_q.y_offset);
			REG_Y_GAIN:       prdata = PDATA_W'(cfg_q.y_gain);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (push) begin
			wp_q <= (wp_q == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_q + RING_AW'(1);
		end
	end

	smmd_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (push),
		.waddr (wp_q),
		.wdata (s_tdata[SAMPLE_BITS-1:0]),
		.re    (rd_req.en),
		.raddr (rd_req.addr),
		.rdata (rd_data)
	);

	smmd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.pixel_index   (s_tdata[SAMPLE_BITS +: COL_W]),
		.cfg           (cfg_q),
		.write_pointer (wp_q),
		.rd_req        (rd_req),
		.rd_data       (rd_data),
		.idle          (core_idle),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res)
	);

	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule
